[rtl/abca_pkg.sv]
package abca_pkg;

  // Field widths of the item and result words
  localparam int RAW_W     = 11;
  localparam int NUM_RAW   = 8;
  localparam int CMD_W     = 2;
  localparam int CNT_W     = 4;
  localparam int CORR_W    = 11;
  localparam int SUM_W     = 14;
  localparam int OUT_IDX_W = 10;
  localparam int HALF_W    = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // Half-buffer flag codes
  localparam logic [HALF_W-1:0] HALF_NONE   = 2'd0;
  localparam logic [HALF_W-1:0] HALF_FIRST  = 2'd1;
  localparam logic [HALF_W-1:0] HALF_SECOND = 2'd2;

  // Correction constants: offset removed from the low byte, then gain/256
  localparam logic [7:0] LO_OFFSET = 8'd21;
  localparam logic [8:0] LO_GAIN   = 9'd279;

  localparam logic [CNT_W-1:0] READINGS_RESET = 4'd8;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [CORR_W-1:0] corr_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Sequencer verdict for one word
  typedef struct packed {
    logic              sample;
    logic [HALF_W-1:0] half;
  } abca_seq_t;

endpackage

[rtl/abca_ifs.sv]
interface abca_item_if import abca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  raw_t             raw_0;
  raw_t             raw_1;
  raw_t             raw_2;
  raw_t             raw_3;
  raw_t             raw_4;
  raw_t             raw_5;
  raw_t             raw_6;
  raw_t             raw_7;

  modport source (output valid, cmd, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5, raw_6, raw_7,
                  input ready);
  modport sink (input valid, cmd, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5, raw_6, raw_7,
                output ready);
endinterface

interface abca_result_if import abca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 sample_valid;
  sum_t                 sample_value;
  logic [OUT_IDX_W-1:0] write_index;
  logic [HALF_W-1:0]    half_ready;

  modport source (output valid, sample_valid, sample_value, write_index, half_ready,
                  input ready);
  modport sink (input valid, sample_valid, sample_value, write_index, half_ready,
                output ready);
endinterface

interface abca_cfg_if import abca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] readings_used;

  modport source (output valid, readings_used, input ready);
  modport sink (input valid, readings_used, output ready);
endinterface

[rtl/abca_correct.sv]
module abca_correct import abca_pkg::*; (
  input  raw_t  raw,
  output corr_t corr
);

  logic [RAW_W-1:0] inv;
  logic [7:0]       lo;
  logic [7:0]       lo_off;
  logic [16:0]      scaled;

  // Invert, then scale the low byte above the offset and add back the high bits
  always_comb begin
    inv    = ~raw;
    lo     = inv[7:0];
    lo_off = lo - LO_OFFSET;
    scaled = 17'(lo_off) * 17'(LO_GAIN);
    if (lo > LO_OFFSET) begin
      corr = {inv[10:8], scaled[15:8]};
    end else begin
      corr = {inv[10:8], 8'd0};
    end
  end

endmodule

[rtl/abca_accum.sv]
module abca_accum import abca_pkg::*; #(
  parameter int MAX_READINGS = 8
) (
  input  logic [NUM_RAW-1:0][RAW_W-1:0] raw,
  input  logic [CNT_W-1:0]              readings_used,
  output sum_t                          sum
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READINGS);

  corr_t            corr [NUM_RAW];
  logic [CNT_W-1:0] n_eff;

  // One correction lane per reading
  for (genvar i = 0; i < NUM_RAW; i++) begin : g_lane
    abca_correct u_correct (
      .raw  (raw[i]),
      .corr (corr[i])
    );
  end

  // Saturate the count, then add the lanes in use
  always_comb begin
    n_eff = (readings_used > MAX_CNT) ? MAX_CNT : readings_used;
    sum   = '0;
    for (int i = 0; i < NUM_RAW; i++) begin
      if (CNT_W'(i) < n_eff) begin
        sum = sum + SUM_W'(corr[i]);
      end
    end
  end

endmodule

[rtl/abca_seq.sv]
module abca_seq import abca_pkg::*; #(
  parameter int BUF_SAMPLES = 1024,
  localparam int IDX_W = $clog2(BUF_SAMPLES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [CMD_W-1:0] cmd,
  output abca_seq_t        verdict,
  output logic [IDX_W-1:0] index
);

  localparam logic [IDX_W-1:0] HALF_LAST = IDX_W'(BUF_SAMPLES / 2 - 1);
  localparam logic [IDX_W-1:0] BUF_LAST  = IDX_W'(BUF_SAMPLES - 1);

  logic running;
  logic skip_first;

  // Decide whether this word carries a sample, and flag half fills
  always_comb begin
    verdict.sample = (cmd == CMD_TICK) && running && !skip_first;
    verdict.half   = HALF_NONE;
    if (verdict.sample) begin
      if (index == HALF_LAST) begin
        verdict.half = HALF_FIRST;
      end else if (index == BUF_LAST) begin
        verdict.half = HALF_SECOND;
      end
    end
  end

  // Advance capture state once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      skip_first <= 1'b0;
      index      <= '0;
    end else if (advance) begin
      case (cmd)
        CMD_START: begin
          running    <= 1'b1;
          skip_first <= 1'b1;
          index      <= '0;
        end
        CMD_STOP: begin
          running <= 1'b0;
        end
        CMD_TICK: begin
          if (running) begin
            if (skip_first) begin
              skip_first <= 1'b0;
              index      <= '0;
            end else if (index == BUF_LAST) begin
              index <= '0;
            end else begin
              index <= index + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/adc_burst_correct_accumulate.sv]
// Burst ADC corrector: each input word carries a command and eight raw 11-bit
// readings. Ticks while running produce one summed, corrected sample along with
// its ping-pong buffer write index and a half-full flag; start, stop, unused codes, the
// first tick after a start and ticks while stopped produce a result word with
// sample_valid low and all other fields zero. Every input word yields exactly one
// result word, passed through the input register and then the result register,
// and a new word can be taken every cycle when the result side keeps up.
// The readings_used register (reset 8) may be written at any time the block is idle;
// its write channel is always ready.
module adc_burst_correct_accumulate import abca_pkg::*; #(
  parameter int BUF_SAMPLES  = 1024,
  parameter int MAX_READINGS = 8
) (
  input logic           clk,
  input logic           rst,
  abca_item_if.sink     item,
  abca_result_if.source result,
  abca_cfg_if.sink      cfg
);

  localparam int IDX_W = $clog2(BUF_SAMPLES);

  logic                          s1_valid;
  logic [CMD_W-1:0]              s1_cmd;
  logic [NUM_RAW-1:0][RAW_W-1:0] s1_raw;
  logic                          s1_advance;
  logic [CNT_W-1:0]              readings_used;
  sum_t                          sum;
  abca_seq_t                     verdict;
  logic [IDX_W-1:0]              index;

  assign s1_advance = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_advance;
  assign cfg.ready  = 1'b1;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      readings_used <= READINGS_RESET;
    end else if (cfg.valid) begin
      readings_used <= cfg.readings_used;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_cmd <= item.cmd;
      s1_raw <= {item.raw_7, item.raw_6, item.raw_5, item.raw_4,
                 item.raw_3, item.raw_2, item.raw_1, item.raw_0};
    end
  end

  abca_accum #(
    .MAX_READINGS (MAX_READINGS)
  ) u_accum (
    .raw           (s1_raw),
    .readings_used (readings_used),
    .sum           (sum)
  );

  abca_seq #(
    .BUF_SAMPLES (BUF_SAMPLES)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .cmd     (s1_cmd),
    .verdict (verdict),
    .index   (index)
  );

  // Load the result word; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.sample_valid <= verdict.sample;
      result.sample_value <= verdict.sample ? sum : '0;
      result.write_index  <= verdict.sample ? OUT_IDX_W'(index) : '0;
      result.half_ready   <= verdict.half;
    end
  end

endmodule

[rtl/abca_checker.sv]
module abca_checker import abca_pkg::*; #(
  parameter int BUF_SAMPLES = 1024
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 sample_valid,
  input sum_t                 sample_value,
  input logic [OUT_IDX_W-1:0] write_index,
  input logic [HALF_W-1:0]    half_ready
);

  localparam logic [OUT_IDX_W-1:0] HALF_IDX = OUT_IDX_W'(BUF_SAMPLES / 2 - 1);
  localparam logic [OUT_IDX_W-1:0] LAST_IDX = OUT_IDX_W'(BUF_SAMPLES - 1);

  // A word without a sample carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sample_valid) |->
      (sample_value == '0 && write_index == '0 && half_ready == HALF_NONE))
    else $error("empty result word has nonzero fields");

  // First-half flag only at the last index of the first half
  a_half_first: assert property (@(posedge clk) disable iff (rst)
    (out_valid && half_ready == HALF_FIRST) |-> write_index == HALF_IDX)
    else $error("first-half flag at wrong index");

  // Second-half flag only at the last buffer index
  a_half_second: assert property (@(posedge clk) disable iff (rst)
    (out_valid && half_ready == HALF_SECOND) |-> write_index == LAST_IDX)
    else $error("second-half flag at wrong index");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sample_valid) && $stable(sample_value) &&
       $stable(write_index) && $stable(half_ready)))
    else $error("result word changed while stalled");

endmodule

bind adc_burst_correct_accumulate abca_checker #(
  .BUF_SAMPLES (BUF_SAMPLES)
) u_abca_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .sample_valid (result.sample_valid),
  .sample_value (result.sample_value),
  .write_index  (result.write_index),
  .half_ready   (result.half_ready)
);

[verif/tb_adc_burst_correct_accumulate.sv]
`timescale 1ns / 1ps

module tb_adc_burst_correct_accumulate;
  import abca_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef raw_t burst_t [NUM_RAW];

  // Predicts one result word per input word and checks results in order
  class sample_scoreboard;
    localparam int BUF_DEPTH = 1024;

    typedef struct {
      logic                 valid;
      sum_t                 value;
      logic [OUT_IDX_W-1:0] index;
      logic [HALF_W-1:0]    half;
    } sample_t;

    sample_t          expected_samples[$];
    logic [CNT_W-1:0] readings_used;
    bit               running;
    bit               skip_first;
    int unsigned      next_index;
    int               errors;
    int               words;
    int               samples;
    int               first_halves;
    int               second_halves;

    function new();
      readings_used = READINGS_RESET;
      running       = 1'b0;
      skip_first    = 1'b0;
      next_index    = 0;
      errors        = 0;
      words         = 0;
      samples       = 0;
      first_halves  = 0;
      second_halves = 0;
    endfunction

    function void set_readings(logic [CNT_W-1:0] v);
      readings_used = v;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // Invert, drop the low-byte offset, apply the gain and add the high bits
    function corr_t corrected_reading(raw_t raw);
      logic [RAW_W-1:0] v;
      int lo;
      int c;
      v  = ~raw;
      lo = v[7:0];
      c  = {v[10:8], 8'h00};
      if (lo > int'(LO_OFFSET))
        c += ((lo - int'(LO_OFFSET)) * int'(LO_GAIN)) >> 8;
      return corr_t'(c);
    endfunction

    // Advance the predicted state for one accepted word
    function void note_word(logic [CMD_W-1:0] cmd, raw_t raws [NUM_RAW]);
      sample_t s;
      int n;
      int sum;
      s.valid = 1'b0;
      s.value = '0;
      s.index = '0;
      s.half  = HALF_NONE;
      sum = 0;
      words++;
      if (cmd == CMD_START) begin
        running    = 1'b1;
        skip_first = 1'b1;
        next_index = 0;
      end else if (cmd == CMD_STOP) begin
        running = 1'b0;
      end else if (cmd == CMD_TICK && running) begin
        if (skip_first) begin
          skip_first = 1'b0;
          next_index = 0;
        end else begin
          n = (readings_used > NUM_RAW) ? NUM_RAW : int'(readings_used);
          for (int i = 0; i < n; i++)
            sum += corrected_reading(raws[i]);
          s.valid = 1'b1;
          s.value = sum_t'(sum);
          s.index = next_index[OUT_IDX_W-1:0];
          next_index++;
          if (next_index == BUF_DEPTH / 2) begin
            s.half = HALF_FIRST;
            first_halves++;
          end else if (next_index == BUF_DEPTH) begin
            s.half = HALF_SECOND;
            second_halves++;
          end
          if (next_index >= BUF_DEPTH)
            next_index = 0;
          samples++;
        end
      end
      expected_samples.push_back(s);
    endfunction

    task report(string what);
      if (errors < 40)
        $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Compare one result word with the oldest prediction
    task check_word(logic sv, sum_t value, logic [OUT_IDX_W-1:0] index,
                    logic [HALF_W-1:0] half);
      sample_t e;
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected result word valid=%0b value=%0d index=%0d half=%0d",
                         sv, value, index, half));
      end else begin
        e = expected_samples.pop_front();
        if (sv !== e.valid)
          report($sformatf("sample_valid %0b, predicted %0b", sv, e.valid));
        if (value !== e.value)
          report($sformatf("sample_value %0d, predicted %0d", value, e.value));
        if (index !== e.index)
          report($sformatf("write_index %0d, predicted %0d", index, e.index));
        if (half !== e.half)
          report($sformatf("half_ready %0d, predicted %0d", half, e.half));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  abca_item_if   item_ch ();
  abca_result_if res_ch ();
  abca_cfg_if    cfg_ch ();

  adc_burst_correct_accumulate uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  sample_scoreboard board;
  burst_t           burst;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               run_left;
  bit               long_run_due;

  always #6 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check accepted results, then stall the result side at random
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_word(res_ch.sample_valid, res_ch.sample_value, res_ch.write_index,
                       res_ch.half_ready);
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offer one word, idling first at random; hold it until accepted
  task automatic send_word(logic [CMD_W-1:0] cmd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd   <= cmd;
    item_ch.raw_0 <= burst[0];
    item_ch.raw_1 <= burst[1];
    item_ch.raw_2 <= burst[2];
    item_ch.raw_3 <= burst[3];
    item_ch.raw_4 <= burst[4];
    item_ch.raw_5 <= burst[5];
    item_ch.raw_6 <= burst[6];
    item_ch.raw_7 <= burst[7];
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    board.note_word(cmd, burst);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic quiesce();
    item_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_readings(logic [CNT_W-1:0] v);
    quiesce();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.readings_used <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.set_readings(v);
  endtask

  task automatic set_burst(raw_t v);
    for (int i = 0; i < NUM_RAW; i++)
      burst[i] = v;
  endtask

  // Mostly full-range values, some near the low-byte offset and the extremes
  function automatic raw_t pick_raw();
    logic [RAW_W-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        v = {3'($urandom_range(0, 7)), 8'($urandom_range(19, 23))};
        return ~v;
      end
      1: return $urandom_range(0, 1) ? '0 : '1;
      default: return raw_t'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic fill_random_burst();
    for (int i = 0; i < NUM_RAW; i++)
      burst[i] = pick_raw();
  endtask

  // Build start-then-ticks runs with some noise; the first run is over a buffer's length of words
  task automatic pick_command(output logic [CMD_W-1:0] cmd);
    int unsigned r;
    if (run_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        cmd = CMD_START;
        if (long_run_due || $urandom_range(0, 19) == 0)
          run_left = $urandom_range(1030, 1090);
        else
          run_left = $urandom_range(1, 60);
        long_run_due = 1'b0;
      end else if (r < 8) begin
        cmd      = CMD_STOP;
        run_left = $urandom_range(0, 3);
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK;
      end
    end else begin
      run_left--;
      cmd = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : CMD_TICK;
    end
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] phase_setting;
    board = new();
    clk   = 1'b0;
    rst   = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.cmd   = CMD_TICK;
    item_ch.raw_0 = '0;
    item_ch.raw_1 = '0;
    item_ch.raw_2 = '0;
    item_ch.raw_3 = '0;
    item_ch.raw_4 = '0;
    item_ch.raw_5 = '0;
    item_ch.raw_6 = '0;
    item_ch.raw_7 = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.readings_used = READINGS_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_left      = 0;
    long_run_due  = 1'b1;
    set_burst('0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: count above the maximum saturates
    write_readings(4'd15);
    fill_random_burst();
    send_word(CMD_TICK);      // tick while stopped
    send_word(CMD_STOP);      // stop while stopped
    send_word(CMD_UNUSED);
    send_word(CMD_START);
    send_word(CMD_TICK);      // first tick after start is discarded
    set_burst('0);
    send_word(CMD_TICK);      // largest corrected value on every lane
    set_burst('1);
    send_word(CMD_TICK);      // zero on every lane
    set_burst(11'h7EA);
    send_word(CMD_TICK);      // low byte exactly at the offset
    set_burst(11'h7E9);
    send_word(CMD_TICK);      // one above the offset
    set_burst(11'h7EB);
    send_word(CMD_TICK);      // one below the offset
    send_word(CMD_UNUSED);    // unused code while running
    fill_random_burst();
    send_word(CMD_START);     // restart while running
    send_word(CMD_TICK);
    fill_random_burst();
    send_word(CMD_TICK);
    send_word(CMD_STOP);
    send_word(CMD_TICK);

    // Directed: no readings summed
    write_readings(4'd0);
    send_word(CMD_START);
    send_word(CMD_TICK);
    fill_random_burst();
    send_word(CMD_TICK);

    // Directed: a single reading
    write_readings(4'd1);
    fill_random_burst();
    send_word(CMD_TICK);
    set_burst('0);
    send_word(CMD_TICK);

    write_readings(4'd8);
    fill_random_burst();
    send_word(CMD_TICK);

    // Random: three idling profiles, a new count in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 86;
          phase_setting = 4'd8;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 6;
          phase_setting = CNT_W'($urandom_range(0, 15));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          phase_setting = CNT_W'($urandom_range(1, 7));
        end
      endcase
      write_readings(phase_setting);
      for (int k = 0; k < 535; k++) begin
        if (phase == 1 && k == 200)
          quiesce();
        pick_command(cmd);
        fill_random_burst();
        send_word(cmd);
      end
    end

    quiesce();
    repeat (6) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d predicted words never arrived", board.pending()));

    $display("Covered %0d words and %0d samples, %0d first-half and %0d second-half flags,",
             board.words, board.samples, board.first_halves, board.second_halves);
    $display("with reading counts 15, 0, 1, 8, then 8 and two random ones; %0d mismatches.",
             board.errors);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
